// File: hdl/spq_pkg.sv
// Shared codes for the stable priority queue: operations and status values.
`default_nettype none
package spq_pkg;

    localparam int VALUE_BITS = 32;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage
`default_nettype wire

// File: hdl/spq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/stable_priority_queue.sv
// Top level of the stable priority queue: sequencer around a ring of entries held in RAM.
//
// The queue keeps up to CAPACITY entries (value plus signed priority) sorted in a ring
// buffer inside one RAM, highest priority at the head, equal priorities in arrival order.
// A head pointer makes an extract cheap: drop the head by advancing the pointer, then read
// the new head value into a cached register. An insert walks from the tail toward the head,
// one RAM read and one write per entry of lower priority that moves back a slot. Every
// transaction on the s_ channel yields exactly one transaction on the m_ channel. An insert
// alternates ST_ISCAN, which places the entry at the head or fetches the entry before, and
// ST_IRD, which compares the fetched entry and shifts it back or places the new one; an
// extract passes through ST_XRD to capture the new head unless it leaves the queue empty;
// an insert into a full queue or an extract from an empty one goes straight to ST_OUT.
// ST_OUT waits while the previous result still sits in the output register without m_ready.
// The registered RAM read port is why each fetch in the walk has a state of its own. s_ready
// is high while the sequencer is idle, so a new transaction is taken even while the previous
// result still waits in the output register. The RAM needs no clearing: only slots inside the
// ring's occupied range are ever read.
`default_nettype none
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_operation,
    input  wire logic signed [VALUE_BITS-1:0]    s_item_value,
    input  wire logic signed [PRIORITY_BITS-1:0] s_item_priority,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [VALUE_BITS-1:0]         m_taken_value,
    output logic                                 m_taken_valid,
    output logic signed [VALUE_BITS-1:0]         m_head_value,
    output logic                                 m_queue_empty,
    output logic [1:0]                           m_status
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = VALUE_BITS + PRIORITY_BITS;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [IDX_W:0]   CAP_SUM = (IDX_W + 1)'(CAPACITY);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISCAN = 3'd1;  // insert: place at slot or fetch the one before
    localparam logic [2:0] ST_IRD   = 3'd2;  // insert: compare fetched entry, shift or place
    localparam logic [2:0] ST_XRD   = 3'd3;  // extract: capture the new head value
    localparam logic [2:0] ST_OUT   = 3'd4;  // hand the result to the output register

    // Map a position counted from the head to a RAM address (ring wraps at CAPACITY).
    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= CAP_SUM) begin
            sum = sum - CAP_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [2:0]                      state_reg,      state_next;
    logic [CNT_W-1:0]                count_reg,      count_next;
    logic [IDX_W-1:0]                head_reg,       head_next;
    logic signed [VALUE_BITS-1:0]    head_val_reg,   head_val_next;
    logic [IDX_W-1:0]                idx_reg,        idx_next;
    logic signed [VALUE_BITS-1:0]    new_val_reg,    new_val_next;
    logic signed [PRIORITY_BITS-1:0] new_prio_reg,   new_prio_next;
    logic signed [VALUE_BITS-1:0]    res_taken_reg,  res_taken_next;
    logic                            res_tvalid_reg, res_tvalid_next;
    logic [1:0]                      res_status_reg, res_status_next;

    logic                            m_valid_reg,    m_valid_next;
    logic signed [VALUE_BITS-1:0]    m_taken_reg,    m_taken_next;
    logic                            m_tvalid_reg,   m_tvalid_next;
    logic signed [VALUE_BITS-1:0]    m_head_reg,     m_head_next;
    logic                            m_empty_reg,    m_empty_next;
    logic [1:0]                      m_status_reg,   m_status_next;

    // RAM ports
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [WORD_W-1:0]               wr_data;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_addr;
    logic [WORD_W-1:0]               rd_data;
    logic signed [PRIORITY_BITS-1:0] rd_prio;
    logic                            s_fire;

    spq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign rd_prio = rd_data[PRIORITY_BITS-1:0];

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        head_val_next   = head_val_reg;
        idx_next        = idx_reg;
        new_val_next    = new_val_reg;
        new_prio_next   = new_prio_reg;
        res_taken_next  = res_taken_reg;
        res_tvalid_next = res_tvalid_reg;
        res_status_next = res_status_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_taken_next  = m_taken_reg;
        m_tvalid_next = m_tvalid_reg;
        m_head_next   = m_head_reg;
        m_empty_next  = m_empty_reg;
        m_status_next = m_status_reg;

        wr_en   = 1'b0;
        wr_addr = ring_addr(head_reg, idx_reg);
        wr_data = {new_val_reg, new_prio_reg};
        rd_en   = 1'b0;
        rd_addr = ring_addr(head_reg, idx_reg - IDX_W'(1));

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    res_taken_next  = '0;
                    res_tvalid_next = 1'b0;
                    res_status_next = STATUS_OK;
                    if (s_operation == OP_INSERT) begin
                        if (count_reg == CAP_CNT) begin
                            // full: drop the insert, report it
                            res_status_next = STATUS_FULL;
                            state_next      = ST_OUT;
                        end else begin
                            new_val_next  = s_item_value;
                            new_prio_next = s_item_priority;
                            idx_next      = count_reg[IDX_W-1:0];
                            state_next    = ST_ISCAN;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_OUT;
                        end else begin
                            // pop the cached head, advance the ring
                            res_taken_next  = head_val_reg;
                            res_tvalid_next = 1'b1;
                            count_next      = count_reg - CNT_W'(1);
                            head_next       = ring_addr(head_reg, IDX_W'(1));
                            if (count_reg == CNT_W'(1)) begin
                                state_next = ST_OUT;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = ring_addr(head_reg, IDX_W'(1));
                                state_next = ST_XRD;
                            end
                        end
                    end
                end
            end

            ST_ISCAN: begin
                if (idx_reg == '0) begin
                    // new entry becomes the head
                    wr_en         = 1'b1;
                    head_val_next = new_val_reg;
                    count_next    = count_reg + CNT_W'(1);
                    state_next    = ST_OUT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_IRD;
                end
            end

            ST_IRD: begin
                wr_en = 1'b1;
                if (rd_prio >= new_prio_reg) begin
                    // stop behind every entry of higher or equal priority
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_OUT;
                end else begin
                    // move the lower-priority entry back one slot
                    wr_data    = rd_data;
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = ST_ISCAN;
                end
            end

            ST_XRD: begin
                head_val_next = rd_data[WORD_W-1:PRIORITY_BITS];
                state_next    = ST_OUT;
            end

            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_taken_next  = res_taken_reg;
                    m_tvalid_next = res_tvalid_reg;
                    m_head_next   = (count_reg == '0) ? '0 : head_val_reg;
                    m_empty_next  = (count_reg == '0);
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        head_val_reg   <= head_val_next;
        idx_reg        <= idx_next;
        new_val_reg    <= new_val_next;
        new_prio_reg   <= new_prio_next;
        res_taken_reg  <= res_taken_next;
        res_tvalid_reg <= res_tvalid_next;
        res_status_reg <= res_status_next;
        m_taken_reg    <= m_taken_next;
        m_tvalid_reg   <= m_tvalid_next;
        m_head_reg     <= m_head_next;
        m_empty_reg    <= m_empty_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_taken_value = m_taken_reg;
    assign m_taken_valid = m_tvalid_reg;
    assign m_head_value  = m_head_reg;
    assign m_queue_empty = m_empty_reg;
    assign m_status      = m_status_reg;

    // occupancy never exceeds the ring size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // a successful extract drops exactly one entry
    a_extract_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == OP_EXTRACT && count_reg != '0)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("extract did not drop one entry");

    // the RAM is written only while an insert walks the ring
    a_write_in_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_ISCAN || state_reg == ST_IRD))
        else $error("RAM write outside an insert");

    // a result held for the consumer stays put until taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_taken_value)))
        else $error("pending result changed before it was taken");

endmodule
`default_nettype wire

// File: sim/stable_priority_queue_test.sv
// Testbench for stable_priority_queue: directed table plus random traffic against a predictor.
`default_nettype none
module stable_priority_queue_test;
    import spq_pkg::*;

    // Build the queue at its default size; the predictor below uses the same figures.
    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;

    // An insert walks past at most DEPTH - 1 entries; SETTLE_CYCLES leaves room for the longest one.
    localparam int SETTLE_CYCLES  = 3 + 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int RANDOM_ITEMS   = 1225;

    // One result transaction, field by field, at the widths of the m_ ports.
    typedef struct packed {
        logic [VALUE_BITS-1:0] taken_value;
        logic                  taken_valid;
        logic [VALUE_BITS-1:0] head_value;
        logic                  queue_empty;
        logic [1:0]            status;
    } spq_result_t;

    // One row of the directed table; want is used only when typed is set.
    typedef struct {
        logic                  op;
        logic [VALUE_BITS-1:0] value;
        logic [PRIO_BITS-1:0]  prio;
        bit                    typed;
        spq_result_t           want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    logic [VALUE_BITS-1:0] s_item_value;
    logic [PRIO_BITS-1:0]  s_item_priority;
    logic                  m_valid;
    logic                  m_ready;
    logic [VALUE_BITS-1:0] m_taken_value;
    logic                  m_taken_valid;
    logic [VALUE_BITS-1:0] m_head_value;
    logic                  m_queue_empty;
    logic [1:0]            m_status;

    stable_priority_queue #(
        .CAPACITY      (DEPTH),
        .PRIORITY_BITS (PRIO_BITS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_taken_value   (m_taken_value),
        .m_taken_valid   (m_taken_valid),
        .m_head_value    (m_head_value),
        .m_queue_empty   (m_queue_empty),
        .m_status        (m_status)
    );

    // Predictor state: a sorted copy of the queue, head at slot 0.
    logic [VALUE_BITS-1:0]       held_values [DEPTH];
    logic signed [PRIO_BITS-1:0] held_prios  [DEPTH];
    int                          held_count;

    spq_result_t expected_results [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count;
    int          results_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_out_req;

    // 12-unit clock period.
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one transaction to the predictor and return the result the block must give.
    function automatic spq_result_t predict_queue_step(
        input logic                        op,
        input logic [VALUE_BITS-1:0]       value,
        input logic signed [PRIO_BITS-1:0] prio
    );
        spq_result_t res;
        int          slot;
        res = '0;
        res.status = STATUS_OK;
        if (op == OP_INSERT) begin
            if (held_count >= DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                // Go behind every entry of greater or equal priority: equal ones stay FIFO.
                slot = 0;
                while (slot < held_count && held_prios[slot] >= prio)
                    slot++;
                for (int i = held_count; i > slot; i--) begin
                    held_values[i] = held_values[i-1];
                    held_prios[i]  = held_prios[i-1];
                end
                held_values[slot] = value;
                held_prios[slot]  = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.taken_value = held_values[0];
            res.taken_valid = 1'b1;
            for (int i = 1; i < held_count; i++) begin
                held_values[i-1] = held_values[i];
                held_prios[i-1]  = held_prios[i];
            end
            held_count--;
        end
        res.head_value  = (held_count > 0) ? held_values[0] : '0;
        res.queue_empty = (held_count == 0);
        return res;
    endfunction

    function automatic void add_row(
        input logic                  op,
        input logic [VALUE_BITS-1:0] value,
        input logic [PRIO_BITS-1:0]  prio,
        input bit                    typed,
        input spq_result_t           want
    );
        stim_row_t row;
        row.op    = op;
        row.value = value;
        row.prio  = prio;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Favor a narrow band around zero so that equal priorities are common, and the extremes.
    function automatic logic [PRIO_BITS-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0:             return 8'sd127;
            1:             return -8'sd128;
            2, 3, 4, 5, 6: return PRIO_BITS'($urandom_range(0, 4) - 2);
            default:       return PRIO_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    // Offer one transaction; must be entered at a rising edge. On acceptance, record what the
    // block has to answer: the typed row value where there is one, else the prediction.
    task automatic send_item(
        input logic                  op,
        input logic [VALUE_BITS-1:0] value,
        input logic [PRIO_BITS-1:0]  prio,
        input bit                    typed,
        input spq_result_t           want
    );
        spq_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_item_value    <= value;
        s_item_priority <= prio;
        // Hold valid and payload until the block takes them.
        do
            @(posedge aclk);
        while (!s_ready);
        predicted = predict_queue_step(op, value, prio);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Result side: stall at the current rate; on a hold request, drop ready for a long
    // stretch so that the output register stays full and the sequencer backs up.
    initial begin
        int hold_cnt;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_out_req) begin
                m_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge aclk);
                hold_out_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare every result transaction with the oldest outstanding prediction.
    always @(posedge aclk) begin
        spq_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with none outstanding, status %0d", m_status));
            end else begin
                want = expected_results.pop_front();
                if (m_taken_value !== want.taken_value)
                    report_mismatch($sformatf("taken_value got %h want %h",
                                              m_taken_value, want.taken_value));
                if (m_taken_valid !== want.taken_valid)
                    report_mismatch($sformatf("taken_valid got %b want %b",
                                              m_taken_valid, want.taken_valid));
                if (m_head_value !== want.head_value)
                    report_mismatch($sformatf("head_value got %h want %h",
                                              m_head_value, want.head_value));
                if (m_queue_empty !== want.queue_empty)
                    report_mismatch($sformatf("queue_empty got %b want %b",
                                              m_queue_empty, want.queue_empty));
                if (m_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_status, want.status));
            end
            results_seen++;
        end
    end

    // Watchdog: end the run once neither channel has moved a transaction for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int sent;
        int burst;
        int phase;
        logic op;

        mismatch_count  = 0;
        results_seen    = 0;
        held_count      = 0;
        hold_out_req    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_operation     <= OP_INSERT;
        s_item_value    <= '0;
        s_item_priority <= '0;

        // Directed table. Typed answers only where they follow at a glance.
        // Extract from the empty queue right after reset.
        add_row(OP_EXTRACT, 32'h0000_0000, 8'h00, 1'b1,
                spq_result_t'{32'h0, 1'b0, 32'h0, 1'b1, STATUS_EMPTY});
        // Largest value at the top priority becomes the head.
        add_row(OP_INSERT, 32'h7FFF_FFFF, 8'sd127, 1'b1,
                spq_result_t'{32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0, STATUS_OK});
        // Smallest value at the lowest priority leaves the head alone.
        add_row(OP_INSERT, 32'h8000_0000, -8'sd128, 1'b1,
                spq_result_t'{32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0, STATUS_OK});
        // Equal priorities: later arrivals go behind earlier ones.
        add_row(OP_INSERT, 32'h0000_0000, 8'sd0, 1'b0, '0);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 8'sd0, 1'b0, '0);
        add_row(OP_INSERT, 32'h1234_5678, 8'sd127, 1'b0, '0);
        add_row(OP_INSERT, 32'hA5A5_A5A5, -8'sd1, 1'b0, '0);
        add_row(OP_INSERT, 32'h5A5A_5A5A, 8'sd1, 1'b0, '0);
        add_row(OP_INSERT, 32'h0000_0001, -8'sd128, 1'b0, '0);
        add_row(OP_INSERT, 32'hFFFF_FFFE, 8'sd126, 1'b0, '0);
        add_row(OP_INSERT, 32'h0000_FFFF, -8'sd127, 1'b0, '0);
        add_row(OP_INSERT, 32'hFFFF_0000, 8'sd64, 1'b0, '0);
        add_row(OP_INSERT, 32'h0123_4567, 8'sd0, 1'b0, '0);
        add_row(OP_INSERT, 32'h89AB_CDEF, -8'sd64, 1'b0, '0);
        add_row(OP_INSERT, 32'h7FFF_FFFE, 8'sd127, 1'b0, '0);
        add_row(OP_INSERT, 32'h8000_0001, 8'sd1, 1'b0, '0);
        add_row(OP_INSERT, 32'h0F0F_0F0F, 8'sd2, 1'b0, '0);
        // Queue is full now: drop the insert, head unchanged.
        add_row(OP_INSERT, 32'h3333_3333, 8'sd5, 1'b1,
                spq_result_t'{32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0, STATUS_FULL});
        // Extracts, with junk in the ignored fields.
        add_row(OP_EXTRACT, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0);
        add_row(OP_EXTRACT, 32'h5555_5555, 8'h80, 1'b0, '0);
        add_row(OP_EXTRACT, 32'hAAAA_AAAA, 8'h7F, 1'b0, '0);
        add_row(OP_EXTRACT, 32'h0000_0000, 8'h00, 1'b0, '0);
        add_row(OP_EXTRACT, 32'hC3C3_C3C3, 8'h3C, 1'b0, '0);

        // Hold reset, then release it for good.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].prio,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random traffic in bursts: fill to beyond full, drain to beyond empty, or a mix.
        // Cycle the idling pattern through four phases.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = (sent * 4) / RANDOM_ITEMS;
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            // Once, early on: stop draining results while the sender keeps pushing.
            if (sent == 0)
                hold_out_req = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    burst = DEPTH - held_count + $urandom_range(0, 2);
                    repeat (burst)
                        send_item(OP_INSERT, $urandom, pick_priority(), 1'b0, '0);
                end
                3, 4: begin
                    burst = held_count + $urandom_range(0, 2);
                    repeat (burst)
                        send_item(OP_EXTRACT, $urandom, PRIO_BITS'($urandom), 1'b0, '0);
                end
                default: begin
                    burst = $urandom_range(4, 20);
                    repeat (burst) begin
                        op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_EXTRACT;
                        send_item(op, $urandom, pick_priority(), 1'b0, '0);
                    end
                end
            endcase
            sent += burst;
        end
        s_valid <= 1'b0;

        // Drain: wait for every outstanding result, then give stray ones time to show up.
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
